/* hw/rtl/scmm_pkg.sv */
// ---------------------------------------------------------------------------
// scmm_pkg
// shared types and fixed field widths of the sweep cache
// ---------------------------------------------------------------------------
package scmm_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int STIM_IN_W  = 3;
    localparam int OP_W       = 2;
    localparam int S_TDATA_W  = 24;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 24;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int LEN_REG_W  = 11;
    localparam int LIM_REG_W  = 5;

    localparam logic [LEN_REG_W-1:0] LEN_RESET = 11'd1024;
    localparam logic [LIM_REG_W-1:0] LIM_RESET = 5'd0;

    typedef enum logic [OP_W-1:0] {
        OP_START  = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_END    = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SWEEP_LENGTH = 2'd0,
        CFG_SWEEP_LIMIT  = 2'd1,
        CFG_USE_MEDIAN   = 2'd2,
        CFG_NONE         = 2'd3
    } cfg_idx_t;

    // column unit control
    typedef struct packed {
        logic ins;
        logic first;
    } col_ctl_t;

endpackage

/* hw/rtl/scmm_ram.sv */
// ---------------------------------------------------------------------------
// scmm_ram
// generic simple dual port ram, one write port, registered read port
// ---------------------------------------------------------------------------
module scmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/scmm_div.sv */
// ---------------------------------------------------------------------------
// scmm_div
// restoring divider, one quotient bit per cycle, truncates toward zero
// ---------------------------------------------------------------------------
module scmm_div #(
    parameter int SUM_W = 21,
    parameter int CNT_W = 5
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [SUM_W-1:0]           dividend,
    input  logic [CNT_W-1:0]                  divisor,
    output logic                              done,
    output logic signed [scmm_pkg::SAMPLE_W-1:0] quotient
);

    localparam int CW = $clog2(SUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [SUM_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] div_reg, div_next;
    logic             neg_reg, neg_next;
    logic [CNT_W:0]   trial;
    logic [SUM_W-1:0] signed_quo;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        trial     = {rem_reg, quo_reg[SUM_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(SUM_W);
            rem_next  = '0;
            neg_next  = dividend[SUM_W-1];
            quo_next  = dividend[SUM_W-1] ? $unsigned(-dividend) : $unsigned(dividend);
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = CNT_W'(trial - {1'b0, div_reg});
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[CNT_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
    end

    assign signed_quo = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign quotient   = signed_quo[scmm_pkg::SAMPLE_W-1:0];
    assign done       = done_reg;

endmodule

/* hw/rtl/scmm_col.sv */
// ---------------------------------------------------------------------------
// scmm_col
// sorted column of one index across sweeps, with running sum
// ---------------------------------------------------------------------------
module scmm_col #(
    parameter int MAX_SWEEPS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  scmm_pkg::col_ctl_t                    ctl,
    input  logic signed [scmm_pkg::SAMPLE_W-1:0]  value,
    output logic signed [scmm_pkg::SAMPLE_W+$clog2(MAX_SWEEPS+1)-1:0] sum,
    output logic signed [scmm_pkg::SAMPLE_W-1:0]  median
);

    localparam int CNT_W = $clog2(MAX_SWEEPS + 1);
    localparam int SUM_W = scmm_pkg::SAMPLE_W + CNT_W;
    localparam int SW_W  = MAX_SWEEPS > 1 ? $clog2(MAX_SWEEPS) : 1;

    logic signed [scmm_pkg::SAMPLE_W-1:0] col_reg  [MAX_SWEEPS];
    logic signed [scmm_pkg::SAMPLE_W-1:0] col_next [MAX_SWEEPS];
    logic [CNT_W-1:0]        len_reg, len_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0]        len_eff;
    logic [MAX_SWEEPS-1:0]   gt;
    logic [CNT_W-1:0]        mid;

    always_comb
    begin
        len_eff = ctl.first ? '0 : len_reg;
        for (int j = 0; j < MAX_SWEEPS; j++)
        begin
            gt[j] = (CNT_W'(j) < len_eff) && (col_reg[j] > value);
        end
        for (int j = 0; j < MAX_SWEEPS; j++)
        begin
            if ((CNT_W'(j) < len_eff) && !gt[j])
            begin
                col_next[j] = col_reg[j];
            end
            else if (j > 0 && gt[(j > 0) ? j - 1 : 0])
            begin
                col_next[j] = col_reg[(j > 0) ? j - 1 : 0];
            end
            else
            begin
                col_next[j] = value;
            end
        end
        len_next = len_eff + 1'b1;
        sum_next = ctl.first ? SUM_W'(value) : sum_reg + SUM_W'(value);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else if (ctl.ins)
        begin
            len_reg <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ins)
        begin
            sum_reg <= sum_next;
            for (int j = 0; j < MAX_SWEEPS; j++)
            begin
                col_reg[j] <= col_next[j];
            end
        end
    end

    // upper median sits at floor(n/2)
    assign mid    = len_reg >> 1;
    assign median = col_reg[mid[SW_W-1:0]];
    assign sum    = sum_reg;

endmodule

/* hw/rtl/sweep_cache_mean_median.sv */
// ---------------------------------------------------------------------------
// sweep_cache_mean_median
// stimulus locked sweep cache returning per-index mean or upper median
// ---------------------------------------------------------------------------
// One item is handled at a time. A start, a clear, an overrun sample or an
// end item that commits no sweep passes from idle to the response state and
// then into the output register; an in-range sample first passes the sample
// state for the registered read of the mean and median stores. An end item
// that commits a sweep runs the recompute sequencer over all MAX_SAMPLES
// indices before its result appears: per index it reads the work sweep,
// reads the old column entries one by one from the sweep store and runs the
// serial divider. The sample data lives in four rams (sweep store, work
// sweep, mean and median stores); none needs clearing after reset, a clear
// only resets the per-stimulus sweep counts. A result waits in the output
// register until taken; the next item is taken once the block is back in idle.
// ---------------------------------------------------------------------------
module sweep_cache_mean_median #(
    parameter int NUM_STIM    = 8,
    parameter int MAX_SWEEPS  = 16,
    parameter int MAX_SAMPLES = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input items
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [scmm_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // stim_index, sample_in, zero pad
    input  logic [scmm_pkg::S_TUSER_W-1:0]    s_axis_tuser,  // op
    // results
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [scmm_pkg::M_TDATA_W-1:0]    m_axis_tdata,  // sample_out, recording, overrun, zero pad
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [scmm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [scmm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int SW       = scmm_pkg::SAMPLE_W;
    localparam int STIM_W   = NUM_STIM > 1 ? $clog2(NUM_STIM) : 1;
    localparam int T_W      = MAX_SAMPLES > 1 ? $clog2(MAX_SAMPLES) : 1;
    localparam int IDX_W    = $clog2(MAX_SAMPLES + 1);
    localparam int LEN_W    = IDX_W > scmm_pkg::LEN_REG_W ? IDX_W : scmm_pkg::LEN_REG_W;
    localparam int CNT_W    = $clog2(MAX_SWEEPS + 1);
    localparam int LIM_W    = CNT_W > scmm_pkg::LIM_REG_W ? CNT_W : scmm_pkg::LIM_REG_W;
    localparam int SUM_W    = SW + CNT_W;
    localparam int SS_DEPTH = NUM_STIM * MAX_SWEEPS * MAX_SAMPLES;
    localparam int MS_DEPTH = NUM_STIM * MAX_SAMPLES;
    localparam int SS_AW    = SS_DEPTH > 1 ? $clog2(SS_DEPTH) : 1;
    localparam int MS_AW    = MS_DEPTH > 1 ? $clog2(MS_DEPTH) : 1;

    // one-hot sequencer states
    typedef enum logic [11:0] {
        ST_IDLE     = 12'b0000_0000_0001,
        ST_SAMP     = 12'b0000_0000_0010,
        ST_RESP     = 12'b0000_0000_0100,
        ST_SETUP    = 12'b0000_0000_1000,
        ST_ROW      = 12'b0000_0001_0000,
        ST_WORK_RD  = 12'b0000_0010_0000,
        ST_WORK_INS = 12'b0000_0100_0000,
        ST_OLD_RD   = 12'b0000_1000_0000,
        ST_OLD_INS  = 12'b0001_0000_0000,
        ST_DIV_GO   = 12'b0010_0000_0000,
        ST_DIV      = 12'b0100_0000_0000,
        ST_WB       = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [scmm_pkg::LEN_REG_W-1:0] sweep_length_reg;
    logic [scmm_pkg::LIM_REG_W-1:0] sweep_limit_reg;
    logic                           use_median_reg;

    // sweep control state
    logic [STIM_W-1:0] cur_stim_reg, cur_stim_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              rec_reg, rec_next;
    logic [CNT_W-1:0]  sweep_count_reg [NUM_STIM];

    // pending result
    logic signed [SW-1:0] res_smp_reg, res_smp_next;
    logic                 res_ovr_reg, res_ovr_next;
    logic signed [SW-1:0] live_reg, live_next;
    logic                 has_avg_reg, has_avg_next;

    // recompute sequencer
    logic [CNT_W-1:0] n_old_reg, n_old_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [T_W-1:0]   t_reg, t_next;
    logic [SS_AW-1:0] base_reg, base_next;
    logic [SS_AW-1:0] new_row_reg, new_row_next;
    logic [SS_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [MS_AW-1:0] ms_base_reg, ms_base_next;

    // output register
    logic                     out_valid_reg;
    logic [scmm_pkg::M_TDATA_W-1:0] out_data_reg;

    // item decode
    scmm_pkg::op_t          op;
    logic [STIM_W-1:0]      stim_mod;
    logic signed [SW-1:0]   smp_in;
    logic                   in_xfer;
    logic                   out_free;
    logic                   load_out;

    // counts and limits
    logic [STIM_W-1:0]  cnt_idx;
    logic [CNT_W-1:0]   cnt_rd;
    logic [LEN_W-1:0]   eff_len;
    logic [LIM_W-1:0]   eff_lim;
    logic               cnt_inc;
    logic               cnt_clear;
    logic               cfg_xfer;

    // ram ports
    logic              work_wr_en, work_rd_en;
    logic [SW-1:0]     work_rdata;
    logic              ss_wr_en, ss_rd_en;
    logic [SS_AW-1:0]  ss_wr_addr;
    logic [SW-1:0]     ss_wr_data, ss_rdata;
    logic              ms_wr_en, ms_rd_en;
    logic [MS_AW-1:0]  ms_wr_addr, ms_rd_addr;
    logic [SW-1:0]     mean_rdata, med_rdata;

    // column and divider
    scmm_pkg::col_ctl_t   col_ctl;
    logic signed [SW-1:0] col_value;
    logic signed [SUM_W-1:0] col_sum;
    logic signed [SW-1:0] col_median;
    logic                 div_start, div_done;
    logic signed [SW-1:0] div_quot;

    assign op     = scmm_pkg::op_t'(s_axis_tuser[scmm_pkg::OP_W-1:0]);
    assign smp_in = s_axis_tdata[scmm_pkg::STIM_IN_W +: SW];

    // stimulus taken modulo NUM_STIM by repeated subtraction (at most 8 steps)
    always_comb
    begin
        logic [scmm_pkg::STIM_IN_W-1:0] v;
        v = s_axis_tdata[scmm_pkg::STIM_IN_W-1:0];
        for (int k = 0; k < 8; k++)
        begin
            if (32'(v) >= NUM_STIM)
            begin
                v = scmm_pkg::STIM_IN_W'(32'(v) - NUM_STIM);
            end
        end
        stim_mod = STIM_W'(v);
    end

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign cfg_xfer = cfg_valid && cfg_ready;

    // effective sweep length and limit
    always_comb
    begin
        if (LEN_W'(sweep_length_reg) < LEN_W'(MAX_SAMPLES))
        begin
            eff_len = LEN_W'(sweep_length_reg);
        end
        else
        begin
            eff_len = LEN_W'(MAX_SAMPLES);
        end
        if (sweep_limit_reg == '0 || LIM_W'(sweep_limit_reg) > LIM_W'(MAX_SWEEPS))
        begin
            eff_lim = LIM_W'(MAX_SWEEPS);
        end
        else
        begin
            eff_lim = LIM_W'(sweep_limit_reg);
        end
    end

    // the count is read at the new stimulus for a start, else at the current one
    assign cnt_idx = (state_reg == ST_IDLE && s_axis_tvalid && op == scmm_pkg::OP_START)
                     ? stim_mod : cur_stim_reg;
    assign cnt_rd  = sweep_count_reg[cnt_idx];

    // main sequencer
    always_comb
    begin
        state_next    = state_reg;
        cur_stim_next = cur_stim_reg;
        idx_next      = idx_reg;
        rec_next      = rec_reg;
        res_smp_next  = res_smp_reg;
        res_ovr_next  = res_ovr_reg;
        live_next     = live_reg;
        has_avg_next  = has_avg_reg;
        n_old_next    = n_old_reg;
        i_next        = i_reg;
        t_next        = t_reg;
        base_next     = base_reg;
        new_row_next  = new_row_reg;
        rd_ptr_next   = rd_ptr_reg;
        ms_base_next  = ms_base_reg;
        load_out      = 1'b0;
        cnt_inc       = 1'b0;
        cnt_clear     = 1'b0;
        work_wr_en    = 1'b0;
        work_rd_en    = 1'b0;
        ss_wr_en      = 1'b0;
        ss_rd_en      = 1'b0;
        ms_wr_en      = 1'b0;
        ms_rd_en      = 1'b0;
        ms_rd_addr    = MS_AW'(cur_stim_reg) * MS_AW'(MAX_SAMPLES) + MS_AW'(idx_reg[T_W-1:0]);
        ss_wr_data    = '0;
        col_ctl       = '0;
        col_value     = '0;
        div_start     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    res_smp_next = '0;
                    res_ovr_next = 1'b0;
                    state_next   = ST_RESP;
                    case (op)
                        scmm_pkg::OP_START:
                        begin
                            cur_stim_next = stim_mod;
                            idx_next      = '0;
                            rec_next      = LIM_W'(cnt_rd) < eff_lim;
                        end
                        scmm_pkg::OP_SAMPLE:
                        begin
                            if (LEN_W'(idx_reg) >= eff_len)
                            begin
                                res_ovr_next = 1'b1;
                            end
                            else
                            begin
                                work_wr_en   = rec_reg;
                                ms_rd_en     = 1'b1;
                                has_avg_next = cnt_rd != '0;
                                live_next    = smp_in;
                                idx_next     = idx_reg + 1'b1;
                                state_next   = ST_SAMP;
                            end
                        end
                        scmm_pkg::OP_END:
                        begin
                            rec_next = 1'b0;
                            if (rec_reg && cnt_rd < CNT_W'(MAX_SWEEPS))
                            begin
                                n_old_next = cnt_rd;
                                state_next = ST_SETUP;
                            end
                        end
                        scmm_pkg::OP_CLEAR:
                        begin
                            cnt_clear = 1'b1;
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_SAMP:
            begin
                if (!has_avg_reg)
                begin
                    res_smp_next = live_reg;
                end
                else if (use_median_reg)
                begin
                    res_smp_next = med_rdata;
                end
                else
                begin
                    res_smp_next = mean_rdata;
                end
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SETUP:
            begin
                base_next    = SS_AW'(cur_stim_reg) * SS_AW'(MAX_SWEEPS * MAX_SAMPLES);
                ms_base_next = MS_AW'(cur_stim_reg) * MS_AW'(MAX_SAMPLES);
                t_next       = '0;
                state_next   = ST_ROW;
            end
            ST_ROW:
            begin
                new_row_next = base_reg + SS_AW'(n_old_reg) * SS_AW'(MAX_SAMPLES);
                state_next   = ST_WORK_RD;
            end
            ST_WORK_RD:
            begin
                work_rd_en  = 1'b1;
                rd_ptr_next = base_reg + SS_AW'(t_reg);
                i_next      = '0;
                state_next  = ST_WORK_INS;
            end
            ST_WORK_INS:
            begin
                // indices past the last sample of the sweep commit as zero
                if (IDX_W'(t_reg) < idx_reg)
                begin
                    col_value = work_rdata;
                end
                col_ctl.ins   = 1'b1;
                col_ctl.first = 1'b1;
                ss_wr_en      = 1'b1;
                ss_wr_data    = col_value;
                state_next    = (n_old_reg == '0) ? ST_DIV_GO : ST_OLD_RD;
            end
            ST_OLD_RD:
            begin
                ss_rd_en   = 1'b1;
                state_next = ST_OLD_INS;
            end
            ST_OLD_INS:
            begin
                col_value   = ss_rdata;
                col_ctl.ins = 1'b1;
                rd_ptr_next = rd_ptr_reg + SS_AW'(MAX_SAMPLES);
                i_next      = i_reg + 1'b1;
                state_next  = (i_reg + 1'b1 == n_old_reg) ? ST_DIV_GO : ST_OLD_RD;
            end
            ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_WB;
                end
            end
            ST_WB:
            begin
                ms_wr_en = 1'b1;
                if (t_reg == T_W'(MAX_SAMPLES - 1))
                begin
                    cnt_inc    = 1'b1;
                    state_next = ST_RESP;
                end
                else
                begin
                    t_next     = t_reg + 1'b1;
                    state_next = ST_WORK_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign ss_wr_addr = new_row_reg + SS_AW'(t_reg);
    assign ms_wr_addr = ms_base_reg + MS_AW'(t_reg);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_stim_reg  <= '0;
            idx_reg       <= '0;
            rec_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            n_old_reg     <= '0;
            i_reg         <= '0;
            t_reg         <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cur_stim_reg <= cur_stim_next;
            idx_reg      <= idx_next;
            rec_reg      <= rec_next;
            n_old_reg    <= n_old_next;
            i_reg        <= i_next;
            t_reg        <= t_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        res_smp_reg <= res_smp_next;
        res_ovr_reg <= res_ovr_next;
        live_reg    <= live_next;
        has_avg_reg <= has_avg_next;
        base_reg    <= base_next;
        new_row_reg <= new_row_next;
        rd_ptr_reg  <= rd_ptr_next;
        ms_base_reg <= ms_base_next;
        if (load_out)
        begin
            out_data_reg <= scmm_pkg::M_TDATA_W'({res_ovr_reg, rec_reg, res_smp_reg});
        end
    end

    // per-stimulus sweep counts; a clear or a shrinking limit resets every count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_STIM; s++)
            begin
                sweep_count_reg[s] <= '0;
            end
        end
        else if (cnt_clear || (cfg_xfer && cfg_index == scmm_pkg::CFG_SWEEP_LIMIT
                 && cfg_data[scmm_pkg::LIM_REG_W-1:0] < sweep_limit_reg))
        begin
            for (int s = 0; s < NUM_STIM; s++)
            begin
                sweep_count_reg[s] <= '0;
            end
        end
        else if (cnt_inc)
        begin
            sweep_count_reg[cur_stim_reg] <= sweep_count_reg[cur_stim_reg] + 1'b1;
        end
    end

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_length_reg <= scmm_pkg::LEN_RESET;
            sweep_limit_reg  <= scmm_pkg::LIM_RESET;
            use_median_reg   <= 1'b0;
        end
        else if (cfg_xfer)
        begin
            case (scmm_pkg::cfg_idx_t'(cfg_index))
                scmm_pkg::CFG_SWEEP_LENGTH:
                begin
                    sweep_length_reg <= cfg_data[scmm_pkg::LEN_REG_W-1:0];
                end
                scmm_pkg::CFG_SWEEP_LIMIT:
                begin
                    sweep_limit_reg <= cfg_data[scmm_pkg::LIM_REG_W-1:0];
                end
                scmm_pkg::CFG_USE_MEDIAN:
                begin
                    use_median_reg <= cfg_data[0];
                end
                default:
                begin
                    use_median_reg <= use_median_reg;
                end
            endcase
        end
    end

    // work sweep, written while recording
    scmm_ram #(.WIDTH(SW), .DEPTH(MAX_SAMPLES)) u_work_ram (
        .clk     (clk),
        .wr_en   (work_wr_en),
        .wr_addr (idx_reg[T_W-1:0]),
        .wr_data (smp_in),
        .rd_en   (work_rd_en),
        .rd_addr (t_reg),
        .rd_data (work_rdata)
    );

    // committed sweeps, one row per stimulus and sweep slot
    scmm_ram #(.WIDTH(SW), .DEPTH(SS_DEPTH)) u_sweep_ram (
        .clk     (clk),
        .wr_en   (ss_wr_en),
        .wr_addr (ss_wr_addr),
        .wr_data (ss_wr_data),
        .rd_en   (ss_rd_en),
        .rd_addr (rd_ptr_reg),
        .rd_data (ss_rdata)
    );

    scmm_ram #(.WIDTH(SW), .DEPTH(MS_DEPTH)) u_mean_ram (
        .clk     (clk),
        .wr_en   (ms_wr_en),
        .wr_addr (ms_wr_addr),
        .wr_data (div_quot),
        .rd_en   (ms_rd_en),
        .rd_addr (ms_rd_addr),
        .rd_data (mean_rdata)
    );

    scmm_ram #(.WIDTH(SW), .DEPTH(MS_DEPTH)) u_median_ram (
        .clk     (clk),
        .wr_en   (ms_wr_en),
        .wr_addr (ms_wr_addr),
        .wr_data (col_median),
        .rd_en   (ms_rd_en),
        .rd_addr (ms_rd_addr),
        .rd_data (med_rdata)
    );

    // sorted column and sum of one index across the committed sweeps
    scmm_col #(.MAX_SWEEPS(MAX_SWEEPS)) u_col (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (col_ctl),
        .value  (col_value),
        .sum    (col_sum),
        .median (col_median)
    );

    // mean = sum / count, count is the new sweep total
    scmm_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (col_sum),
        .divisor  (n_old_reg + 1'b1),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign s_axis_tready = state_reg == ST_IDLE;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
